// ----- src/oli_pkg.sv -----
// Package for the ordered list block: opcodes, status codes, result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_NOP        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
  } result_t;

endpackage

`default_nettype wire

// ----- src/oli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/oli_seq.sv -----
// Sequencer for the ordered list: front index, count, scan and close-up passes
// over the entry RAM, result register. Depends on oli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oli_seq #(
  parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        op_i,
  input  wire logic [oli_pkg::DATA_W-1:0]        value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output oli_pkg::result_t                       result_o,
  output logic                                   ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]            ram_waddr_o,
  output logic [oli_pkg::DATA_W-1:0]             ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]            ram_raddr_o,
  input  wire logic [oli_pkg::DATA_W-1:0]        ram_rdata_i
);

  import oli_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_VIEW_F,
    S_VIEW_B,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     k_q, k_d;
  logic [CW-1:0]     kp_q, kp_d;
  logic              pv_q, pv_d;
  logic [DATA_W-1:0] val_q, val_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] fval_q, fval_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic              full;
  logic              empty;
  logic [AW-1:0]     front_dec;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    k_d         = k_q;
    kp_d        = kp_q;
    pv_d        = pv_q;
    val_d       = val_q;
    status_d    = status_q;
    fval_d      = fval_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          status_d = ST_OK;
          k_d      = '0;
          pv_d     = 1'b0;
          state_d  = S_VIEW_F;
          unique case (op_e'(op_i))
            OP_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = front_dec;
                ram_wdata_o = value_i;
                front_d     = front_dec;
                count_d     = count_q + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = ring(front_q, count_q);
                ram_wdata_o = value_i;
                count_d     = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_NOP: begin
              state_d = S_VIEW_F;
            end
          endcase
        end
      end
      S_SCAN: begin
        // reads issued one per cycle, compare against the registered read data
        if (k_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ring(front_q, k_q);
          k_d         = k_q + CW'(1);
        end
        pv_d = (k_q < count_q);
        kp_d = k_q;
        if (pv_q) begin
          if (ram_rdata_i == val_q) begin
            k_d     = kp_q + CW'(1);
            pv_d    = 1'b0;
            state_d = S_SHIFT;
          end else if (kp_q == count_q - CW'(1)) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_VIEW_F;
          end
        end
      end
      S_SHIFT: begin
        // read entry k, write the registered read data one place down
        if (k_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ring(front_q, k_q);
          k_d         = k_q + CW'(1);
        end
        pv_d = (k_q < count_q);
        kp_d = k_q - CW'(1);
        if (pv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = ring(front_q, kp_q);
          ram_wdata_o = ram_rdata_i;
        end
        if (!(k_q < count_q) && !pv_q) begin
          count_d = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            front_d = '0;
          end
          state_d = S_VIEW_F;
        end
      end
      S_VIEW_F: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = front_q;
        state_d     = S_VIEW_B;
      end
      S_VIEW_B: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = ring(front_q, count_q - CW'(1));
        fval_d      = ram_rdata_i;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // read data holds the back entry while the result slot is busy
        if (!out_valid_q || !out_stall_i) begin
          res_d.status      = status_q;
          res_d.entry_count = COUNT_OUT_W'(count_q);
          res_d.front_value = empty ? '0 : $signed(fval_q);
          res_d.back_value  = empty ? '0 : $signed(ram_rdata_i);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      k_q         <= '0;
      kp_q        <= '0;
      pv_q        <= 1'b0;
      val_q       <= '0;
      status_q    <= ST_OK;
      fval_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      k_q         <= k_d;
      kp_q        <= kp_d;
      pv_q        <= pv_d;
      val_q       <= val_d;
      status_q    <= status_d;
      fval_q      <= fval_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ordered_list_insert_remove.sv -----
// Ordered list of up to CAPACITY signed 32-bit values, kept as a deque in a
// ring of one RAM (oli_ram) driven by a sequencer (oli_seq); uses oli_pkg.
// Each transfer inserts at the front, inserts at the back, removes the
// first entry equal to the value, or does nothing, and yields one result:
// status, count, and the front and back values (zero when empty). A removal
// scans one entry a cycle until the match or the back entry, closes the gap
// one entry a cycle and then reads back the ends, at the pace of the single
// read port of the entry RAM. The next transfer is taken once the previous
// result is in the output register.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove #(
  parameter int CAPACITY = oli_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         op_i,
  input  wire logic signed [oli_pkg::DATA_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic [oli_pkg::COUNT_OUT_W-1:0]         entry_count_o,
  output logic signed [oli_pkg::DATA_W-1:0]       front_value_o,
  output logic signed [oli_pkg::DATA_W-1:0]       back_value_o
);

  import oli_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  result_t           res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  oli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  oli_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign status_o      = res.status;
  assign entry_count_o = res.entry_count;
  assign front_value_o = res.front_value;
  assign back_value_o  = res.back_value;

`ifndef SYNTHESIS
  a_empty_view_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == '0 |-> front_value_o == '0 && back_value_o == '0)
    else $error("empty list shows nonzero end values");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == COUNT_OUT_W'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with entries held");
`endif

endmodule

`default_nettype wire

// ----- dv/ordered_list_insert_remove_tb.sv -----
// Self-checking testbench for ordered_list_insert_remove: a queue-fed driver and a
// monitor with random gaps and stalls, checked against an in-bench deque predictor.
// Depends on oli_pkg and the ordered_list_insert_remove RTL.
`timescale 1ns / 1ps

module ordered_list_insert_remove_tb;
  import oli_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int DRAIN_CYCLES = 2 * CAP + 16;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int RAND_ITEMS   = 650;
  localparam int PHASE_LEN    = 32;

  typedef struct {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } list_cmd_t;

  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [1:0]                     in_op     = OP_NOP;
  logic signed [DATA_W-1:0]       in_value  = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [1:0]                     status_o;
  logic [COUNT_OUT_W-1:0]         entry_count_o;
  logic signed [DATA_W-1:0]       front_value_o;
  logic signed [DATA_W-1:0]       back_value_o;

  logic [31:0]                    cycle_cnt = '0;
  int                             in_hold   = 0;
  int                             out_hold  = 0;
  int                             err_cnt   = 0;
  list_cmd_t                      pending_cmds[$];
  list_cmd_t                      next_cmd;
  result_t                        expected_results[$];

  // predictor state: ring store, front index and fill level
  logic signed [DATA_W-1:0]       list_ring [CAP];
  int                             list_head = 0;
  int                             list_held = 0;

  ordered_list_insert_remove #(.CAPACITY(CAP)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (in_op),
    .value_i       (in_value),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int draw_wait();
    if (cycle_cnt[9:8] == 2'b00) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic result_t list_step_result(op_e op, logic signed [DATA_W-1:0] v);
    result_t r;
    int      hit;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (list_held >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_head = (list_head + CAP - 1) % CAP;
          list_ring[list_head] = v;
          list_held++;
        end
      end
      OP_PUSH_BACK: begin
        if (list_held >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_ring[(list_head + list_held) % CAP] = v;
          list_held++;
        end
      end
      OP_REMOVE: begin
        if (list_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int k = 0; k < list_held; k++) begin
            if (hit < 0 && list_ring[(list_head + k) % CAP] == v) hit = k;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int k = hit; k + 1 < list_held; k++) begin
              list_ring[(list_head + k) % CAP] = list_ring[(list_head + k + 1) % CAP];
            end
            list_held--;
            if (list_held == 0) list_head = 0;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_OUT_W'(list_held);
    r.front_value = '0;
    r.back_value  = '0;
    if (list_held > 0) begin
      r.front_value = list_ring[list_head];
      r.back_value  = list_ring[(list_head + list_held - 1) % CAP];
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      note_error("result transfer with no pending expectation");
      return;
    end
    want = expected_results.pop_front();
    if (status_o !== want.status)
      note_error($sformatf("status got %0d want %0d", status_o, want.status));
    if (entry_count_o !== want.entry_count)
      note_error($sformatf("entry_count got %0d want %0d", entry_count_o, want.entry_count));
    if (front_value_o !== want.front_value)
      note_error($sformatf("front_value got %0d want %0d", front_value_o, want.front_value));
    if (back_value_o !== want.back_value)
      note_error($sformatf("back_value got %0d want %0d", back_value_o, want.back_value));
  endtask

  // driver: one transfer at a time, random idle gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_op    <= OP_NOP;
      in_value <= '0;
      in_hold  <= 0;
    end else begin
      if (in_valid && !in_stall_o)
        expected_results.push_back(list_step_result(op_e'(in_op), in_value));
      if (!in_valid || !in_stall_o) begin
        if (in_hold != 0) begin
          in_valid <= 1'b0;
          in_hold  <= in_hold - 1;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_op    <= next_cmd.op;
          in_value <= next_cmd.value;
          in_hold  <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, then stall for a random spell
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      out_stall <= (out_hold != 0);
      if (out_valid_o && !out_stall) begin
        check_result();
        out_hold <= draw_wait();
      end else if (out_hold != 0) begin
        out_hold <= out_hold - 1;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("ordered_list_insert_remove_tb: errors");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] pool [8];
    list_cmd_t                c;
    int                       r;
    bit                       filling;

    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = '0;
    pool[3] = -1;
    pool[4] = 1;
    for (int i = 5; i < 8; i++) pool[i] = $urandom;

    // empty list cases, extremes, not-found, duplicates, fill past full
    c.op = OP_REMOVE;     c.value = 5;          pending_cmds.push_back(c);
    c.op = OP_NOP;        c.value = $urandom;   pending_cmds.push_back(c);
    c.op = OP_PUSH_FRONT; c.value = pool[0];    pending_cmds.push_back(c);
    c.op = OP_PUSH_BACK;  c.value = pool[1];    pending_cmds.push_back(c);
    c.op = OP_PUSH_FRONT; c.value = pool[3];    pending_cmds.push_back(c);
    c.op = OP_PUSH_BACK;  c.value = pool[2];    pending_cmds.push_back(c);
    c.op = OP_REMOVE;     c.value = 12345;      pending_cmds.push_back(c);
    c.op = OP_REMOVE;     c.value = pool[1];    pending_cmds.push_back(c);
    c.op = OP_PUSH_BACK;  c.value = 7;          pending_cmds.push_back(c);
    c.op = OP_PUSH_BACK;  c.value = 7;          pending_cmds.push_back(c);
    c.op = OP_PUSH_FRONT; c.value = 7;          pending_cmds.push_back(c);
    c.op = OP_REMOVE;     c.value = 7;          pending_cmds.push_back(c);
    for (int i = 0; i < 11; i++) begin
      c.op    = (i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      c.value = $urandom;
      pending_cmds.push_back(c);
    end
    c.op = OP_PUSH_FRONT; c.value = pool[1];    pending_cmds.push_back(c);
    c.op = OP_PUSH_BACK;  c.value = pool[0];    pending_cmds.push_back(c);

    // random part in fill-biased and drain-biased phases, switched at random at each phase start
    filling = 1'b0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) filling = ($urandom_range(0, 2) != 0) ? !filling : filling;
      r = $urandom_range(0, 99);
      if (filling)
        c.op = (r < 40) ? OP_PUSH_FRONT : (r < 80) ? OP_PUSH_BACK :
               (r < 95) ? OP_REMOVE : OP_NOP;
      else
        c.op = (r < 12) ? OP_PUSH_FRONT : (r < 24) ? OP_PUSH_BACK :
               (r < 95) ? OP_REMOVE : OP_NOP;
      c.value = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : $urandom;
      pending_cmds.push_back(c);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0)
      $display("ordered_list_insert_remove_tb: clean");
    else
      $display("ordered_list_insert_remove_tb: errors");
    $finish;
  end

endmodule
